// ===== rtl/bfiq_pkg.sv =====
`default_nettype none

package bfiq_pkg;

    // Fixed field widths
    localparam int HASH_W     = 256;
    localparam int CFG_W      = 5;
    localparam int INSERTS_W  = 32;
    localparam int ONES_W     = 17;
    localparam int BYTE_W     = 8;
    localparam int BIT_SEL_W  = 3;
    localparam int IN_DATA_W  = 256;
    localparam int OUT_DATA_W = 56;

    // Index width limits and defaults
    localparam int MIN_INDEX_BITS         = 4;
    localparam int DEF_MAX_INDEX_BITS     = 16;
    localparam int DEF_SUB_HASH_COUNT     = 5;
    localparam logic [CFG_W-1:0] INDEX_BITS_RESET = CFG_W'(16);

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_QUERY  = 1'b1
    } opcode_t;

    typedef enum logic [1:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    typedef struct packed
    {
        logic [ONES_W-1:0]    bits_set;
        logic [INSERTS_W-1:0] items_added;
        logic                 present;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/bloom_filter_insert_query.sv =====
// Bloom filter insert / query engine.
// Input stream (s_axis_*): one item per transfer; tdata carries the 256-bit
// hash (word0 in the low 64 bits), tuser carries the opcode (0 insert,
// 1 query). Sub-hash j is the index_bits-wide slice starting at j*index_bits.
// Output stream (m_axis_*): one result per item, in order: present flag,
// saturating insert count and the count of ones in the bit store.
// Config channel (cfg_*): writes index_bits (clamped to 4..MAX_INDEX_BITS);
// write it only while no item is in flight. The store is not cleared by it.
// The engine takes a new item only after it has handed on the last result. The
// store is a single byte-wide RAM with one read and one write port; each
// sub-hash costs one read and, on an insert whose bit was clear, one write-back,
// overlapped with the next read and forwarded when both touch the same byte.
// Reset: the store is swept to zero, one byte per cycle, over all
// 2^(MAX_INDEX_BITS-3) bytes (8192 by default); s_axis_tready stays low
// meanwhile while config writes are still taken.
// Stall: a result waits in the output register while the next item is
// worked on; the engine holds its finished result until that register frees.
`default_nettype none

module bloom_filter_insert_query #(
    parameter int MAX_INDEX_BITS = bfiq_pkg::DEF_MAX_INDEX_BITS,
    parameter int SUB_HASH_COUNT = bfiq_pkg::DEF_SUB_HASH_COUNT
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    // hash_word0, hash_word1, hash_word2, hash_word3
    input  wire [bfiq_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // opcode
    input  wire                                s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    // present, items_added, bits_set, zero fill
    output logic [bfiq_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire [bfiq_pkg::CFG_W-1:0]          cfg_data
);

    logic [bfiq_pkg::CFG_W-1:0] index_bits_reg;
    logic                       res_valid;
    logic                       res_ready;
    bfiq_pkg::res_t             res;
    logic                       out_valid_reg;
    bfiq_pkg::res_t             out_data_reg;

    // Configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_bits_reg <= bfiq_pkg::INDEX_BITS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            index_bits_reg <= cfg_data;
        end
    end

    bfiq_core #(
        .MAX_INDEX_BITS (MAX_INDEX_BITS),
        .SUB_HASH_COUNT (SUB_HASH_COUNT)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .index_bits (index_bits_reg),
        .item_valid (s_axis_tvalid),
        .item_ready (s_axis_tready),
        .item_op    (bfiq_pkg::opcode_t'(s_axis_tuser)),
        .item_hash  (s_axis_tdata),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // Output register: load when empty or being drained
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(bfiq_pkg::OUT_DATA_W - $bits(bfiq_pkg::res_t))'(0), out_data_reg};

endmodule

`default_nettype wire

// ===== rtl/bfiq_ram.sv =====
`default_nettype none

module bfiq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  wire                      clk,
    input  wire                      wr_en,
    input  wire [$clog2(DEPTH)-1:0] wr_addr,
    input  wire [WIDTH-1:0]          wr_data,
    input  wire                      rd_en,
    input  wire [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read returns the old contents when both ports hit the same entry
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bfiq_core.sv =====
`default_nettype none

module bfiq_core #(
    parameter int MAX_INDEX_BITS = bfiq_pkg::DEF_MAX_INDEX_BITS,
    parameter int SUB_HASH_COUNT = bfiq_pkg::DEF_SUB_HASH_COUNT
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire [bfiq_pkg::CFG_W-1:0]    index_bits,
    input  wire                          item_valid,
    output logic                         item_ready,
    input  wire bfiq_pkg::opcode_t       item_op,
    input  wire [bfiq_pkg::HASH_W-1:0]   item_hash,
    output logic                         res_valid,
    input  wire                          res_ready,
    output bfiq_pkg::res_t               res
);

    localparam int ADDR_W = MAX_INDEX_BITS - bfiq_pkg::BIT_SEL_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int SH_W   = $clog2(SUB_HASH_COUNT + 1);

    localparam logic [SH_W-1:0] LAST_ISSUE = SH_W'(SUB_HASH_COUNT);
    localparam logic [bfiq_pkg::CFG_W-1:0] K_MIN = bfiq_pkg::CFG_W'(bfiq_pkg::MIN_INDEX_BITS);
    localparam logic [bfiq_pkg::CFG_W-1:0] K_MAX = bfiq_pkg::CFG_W'(MAX_INDEX_BITS);

    bfiq_pkg::state_t state_reg, state_next;

    bfiq_pkg::opcode_t                  op_reg;
    logic [bfiq_pkg::CFG_W-1:0]         k_reg;
    logic [bfiq_pkg::CFG_W-1:0]         k_next;
    logic [bfiq_pkg::HASH_W-1:0]        hash_reg;
    logic [SH_W-1:0]                    issue_cnt_reg;
    logic                               p_valid_reg;
    logic [ADDR_W-1:0]                  p_addr_reg;
    logic [bfiq_pkg::BIT_SEL_W-1:0]     p_bit_reg;
    logic                               fwd_valid_reg;
    logic [bfiq_pkg::BYTE_W-1:0]        fwd_data_reg;
    logic                               hit_reg;
    logic [bfiq_pkg::INSERTS_W-1:0]     ins_cnt_reg;
    logic [bfiq_pkg::ONES_W-1:0]        ones_reg;
    logic [ADDR_W-1:0]                  clr_addr_reg;

    logic                               clearing;
    logic                               accept;
    logic                               issue;
    logic                               finish;
    logic [MAX_INDEX_BITS-1:0]          idx_mask;
    logic [MAX_INDEX_BITS-1:0]          idx;
    logic [ADDR_W-1:0]                  rd_addr;
    logic [bfiq_pkg::BYTE_W-1:0]        rd_data;
    logic [bfiq_pkg::BYTE_W-1:0]        byte_cur;
    logic                               bit_hit;
    logic                               wb_set;
    logic                               wr_en;
    logic [ADDR_W-1:0]                  wr_addr;
    logic [bfiq_pkg::BYTE_W-1:0]        wr_data;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bfiq_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = bfiq_pkg::ST_IDLE;
                end
            end
            bfiq_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = bfiq_pkg::ST_RUN;
                end
            end
            bfiq_pkg::ST_RUN:
            begin
                if (p_valid_reg && (issue_cnt_reg == LAST_ISSUE))
                begin
                    state_next = bfiq_pkg::ST_DONE;
                end
            end
            bfiq_pkg::ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = bfiq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bfiq_pkg::ST_CLEAR;
            end
        endcase
    end

    // State-decoded outputs
    always_comb
    begin
        item_ready = 1'b0;
        res_valid  = 1'b0;
        clearing   = 1'b0;
        case (state_reg)
            bfiq_pkg::ST_CLEAR: clearing   = 1'b1;
            bfiq_pkg::ST_IDLE:  item_ready = 1'b1;
            bfiq_pkg::ST_DONE:  res_valid  = 1'b1;
            default:            clearing   = 1'b0;
        endcase
    end

    assign accept = item_valid && item_ready;
    assign finish = (state_reg == bfiq_pkg::ST_RUN) && p_valid_reg
                    && (issue_cnt_reg == LAST_ISSUE);

    // Clamp the index width at item start
    always_comb
    begin
        if (index_bits < K_MIN)
        begin
            k_next = K_MIN;
        end
        else if (index_bits > K_MAX)
        begin
            k_next = K_MAX;
        end
        else
        begin
            k_next = index_bits;
        end
    end

    // Current sub-hash sits in the low bits of the shifted hash
    always_comb
    begin
        for (int i = 0; i < MAX_INDEX_BITS; i++)
        begin
            idx_mask[i] = (bfiq_pkg::CFG_W'(i) < k_reg);
        end
    end

    assign idx     = hash_reg[MAX_INDEX_BITS-1:0] & idx_mask;
    assign rd_addr = idx[MAX_INDEX_BITS-1:bfiq_pkg::BIT_SEL_W];
    assign issue   = (state_reg == bfiq_pkg::ST_RUN) && (issue_cnt_reg < LAST_ISSUE);

    // Take the byte just written when the read raced that write
    assign byte_cur = fwd_valid_reg ? fwd_data_reg : rd_data;
    assign bit_hit  = byte_cur[p_bit_reg];
    assign wb_set   = (state_reg == bfiq_pkg::ST_RUN) && p_valid_reg
                      && (op_reg == bfiq_pkg::OP_INSERT) && !bit_hit;

    // Write port: clearing sweep or set-bit write-back
    always_comb
    begin
        if (clearing)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en   = wb_set;
            wr_addr = p_addr_reg;
            wr_data = byte_cur | (bfiq_pkg::BYTE_W'(1) << p_bit_reg);
        end
    end

    bfiq_ram #(
        .WIDTH (bfiq_pkg::BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (issue),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bfiq_pkg::ST_CLEAR;
            clr_addr_reg  <= '0;
            issue_cnt_reg <= '0;
            p_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
            hit_reg       <= 1'b1;
            ins_cnt_reg   <= '0;
            ones_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            p_valid_reg   <= issue;
            fwd_valid_reg <= wb_set && issue && (rd_addr == p_addr_reg);
            if (clearing)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
            if (accept)
            begin
                issue_cnt_reg <= '0;
                hit_reg       <= 1'b1;
            end
            else if (issue)
            begin
                issue_cnt_reg <= issue_cnt_reg + SH_W'(1);
            end
            if (p_valid_reg && !bit_hit)
            begin
                hit_reg <= 1'b0;
            end
            if (wb_set)
            begin
                ones_reg <= ones_reg + bfiq_pkg::ONES_W'(1);
            end
            // Saturate the insert counter
            if (finish && (op_reg == bfiq_pkg::OP_INSERT) && !(&ins_cnt_reg))
            begin
                ins_cnt_reg <= ins_cnt_reg + bfiq_pkg::INSERTS_W'(1);
            end
        end
    end

    // Item and pipeline payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= item_op;
            k_reg    <= k_next;
            hash_reg <= item_hash;
        end
        else if (issue)
        begin
            hash_reg <= hash_reg >> k_reg;
        end
        if (issue)
        begin
            p_addr_reg <= rd_addr;
            p_bit_reg  <= idx[bfiq_pkg::BIT_SEL_W-1:0];
        end
        fwd_data_reg <= wr_data;
    end

    assign res.present     = (op_reg == bfiq_pkg::OP_QUERY) ? hit_reg : 1'b1;
    assign res.items_added = ins_cnt_reg;
    assign res.bits_set    = ones_reg;

    // Only inserts and the clearing sweep write the store
    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (clearing || (op_reg == bfiq_pkg::OP_INSERT)))
        else $error("store written during a query");

    // Never issue more lookups than sub-hashes
    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        issue_cnt_reg <= LAST_ISSUE)
        else $error("sub-hash issue count overran");

    // Ones count moves by at most one per cycle
    a_ones_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((ones_reg == $past(ones_reg))
                  || (ones_reg == bfiq_pkg::ONES_W'($past(ones_reg) + 1'b1))))
        else $error("ones count jumped");

    // A result appears only after the last sub-hash has been checked
    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> ($past(issue_cnt_reg) == LAST_ISSUE) && $past(p_valid_reg))
        else $error("result raised before all sub-hashes were checked");

endmodule

`default_nettype wire
